[sv/aerl_pkg.sv]
// ============================================================================
// aerl_pkg
// Shared types and constants of the acknowledged event ring log: transaction
// payloads, action codes and parameter defaults.
// ============================================================================
package aerl_pkg;

  localparam int unsigned DefDepth   = 32;
  localparam int unsigned DefTagBits = 16;
  localparam int unsigned TagW       = 16;
  localparam int unsigned SeqW       = 32;
  localparam int unsigned TimeW      = 64;

  typedef enum logic [1:0] {
    ActEmit = 2'd0,
    ActAck  = 2'd1,
    ActRead = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [TagW-1:0]         type_tag;
    logic [TagW-1:0]         channel_tag;
    logic [TagW-1:0]         root_tag;
    logic [TagW-1:0]         actor_tag;
    logic [TagW-1:0]         note_tag;
    logic signed [TimeW-1:0] due_in;
    logic signed [TimeW-1:0] now_time;
    logic [SeqW-1:0]         seq_arg;
  } in_t;

  typedef struct packed {
    logic                    status;
    logic                    has_event;
    logic [SeqW-1:0]         event_seq;
    logic signed [TimeW-1:0] event_due;
    logic [TagW-1:0]         out_type;
    logic [TagW-1:0]         out_channel;
    logic [TagW-1:0]         out_root;
    logic [TagW-1:0]         out_actor;
    logic [TagW-1:0]         out_note;
    logic [SeqW-1:0]         latest_seq;
    logic [SeqW-1:0]         drop_total;
    logic                    last;
  } out_t;

endpackage

[sv/aerl_ram.sv]
// ============================================================================
// aerl_ram
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read data output, valid in the cycle after the read enable.
// ============================================================================
module aerl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/acked_event_ring_log.sv]
// ============================================================================
// acked_event_ring_log
// Fixed-depth event log held in one RAM. Emits with a nonzero type tag append or overwrite
// the oldest entry, acks raise a watermark, and read-since queries list newer entries.
// ============================================================================
// Emits, acks and rejects give their one result in the cycle after acceptance; an
// emit into a full ring passes first through the evict state (RAM read of the
// evicted entry). A read-since query walks the ring one entry per cycle while the
// output is not stalled, then gives its summary result. The next transaction is
// accepted in the cycle the final result is taken, or later.
// Reset clears the counters, the head and the fill count; the RAM is not cleared.
module acked_event_ring_log #(
  parameter int unsigned DEPTH    = aerl_pkg::DefDepth,
  parameter int unsigned TAG_BITS = aerl_pkg::DefTagBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  aerl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output aerl_pkg::out_t out_data_o
);

  import aerl_pkg::*;

  localparam int unsigned IW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned SW      = IW + 1;
  localparam int unsigned TB      = TAG_BITS;
  localparam int unsigned ChanLo  = TB;
  localparam int unsigned RootLo  = 2 * TB;
  localparam int unsigned ActorLo = 3 * TB;
  localparam int unsigned NoteLo  = 4 * TB;
  localparam int unsigned DueLo   = 5 * TB;
  localparam int unsigned SeqLo   = DueLo + TimeW;
  localparam int unsigned EW      = SeqLo + SeqW;

  typedef enum logic [1:0] {
    StIdle,
    StEvict,
    StScan
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   head_q, head_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [SeqW-1:0] seq_q, seq_d;
  logic [SeqW-1:0] drop_q, drop_d;
  logic [SeqW-1:0] ack_q, ack_d;
  in_t             item_q, item_d;
  logic [IW-1:0]   scan_idx_q, scan_idx_d;
  logic [CW-1:0]   scan_cnt_q, scan_cnt_d;
  logic            rvalid_q, rvalid_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;
  logic            load_out;

  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [EW-1:0]   wr_data;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic [EW-1:0]   rd_data;

  logic            out_free;
  logic            accept;
  logic            full;
  logic [SW-1:0]   slot_sum;
  logic [IW-1:0]   app_slot;
  logic [IW-1:0]   head_inc;
  logic [IW-1:0]   scan_inc;
  in_t             cur;
  logic [TimeW-1:0] cur_due;
  logic [SeqW-1:0] seq_inc;
  logic [SeqW-1:0] r_seq;
  logic            match;
  logic            drop_hit;

  function automatic out_t make_result(logic st, logic [SeqW-1:0] sq,
                                       logic [TimeW-1:0] due, logic lst,
                                       logic [SeqW-1:0] lat, logic [SeqW-1:0] drp);
    out_t r;
    r            = '0;
    r.status     = st;
    r.event_seq  = sq;
    r.event_due  = due;
    r.last       = lst;
    r.latest_seq = lat;
    r.drop_total = drp;
    return r;
  endfunction

  aerl_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (fill_q == CW'(DEPTH));
  assign slot_sum   = SW'(head_q) + SW'(fill_q);
  assign app_slot   = (slot_sum >= SW'(DEPTH)) ? IW'(slot_sum - SW'(DEPTH)) : IW'(slot_sum);
  assign head_inc   = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign scan_inc   = (scan_idx_q == IW'(DEPTH - 1)) ? '0 : scan_idx_q + 1'b1;
  assign cur        = (state_q == StEvict) ? item_q : in_data_i;
  assign cur_due    = (cur.due_in != '0) ? cur.due_in : cur.now_time;
  assign seq_inc    = seq_q + 1'b1;
  assign wr_data    = {seq_inc, cur_due, cur.note_tag[TB-1:0], cur.actor_tag[TB-1:0],
                       cur.root_tag[TB-1:0], cur.channel_tag[TB-1:0],
                       cur.type_tag[TB-1:0]};
  assign r_seq      = rd_data[SeqLo +: SeqW];
  assign match      = r_seq > item_q.seq_arg;
  assign drop_hit   = r_seq > ack_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    fill_d     = fill_q;
    seq_d      = seq_q;
    drop_d     = drop_q;
    ack_d      = ack_q;
    item_d     = item_q;
    scan_idx_d = scan_idx_q;
    scan_cnt_d = scan_cnt_q;
    rvalid_d   = rvalid_q;
    load_out   = 1'b0;
    out_d      = '0;
    wr_en      = 1'b0;
    wr_addr    = app_slot;
    rd_en      = 1'b0;
    rd_addr    = head_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          item_d = in_data_i;
          unique case (in_data_i.action)
            ActEmit: begin
              if (in_data_i.type_tag[TB-1:0] == '0) begin
                load_out = 1'b1;
                out_d    = make_result(1'b1, '0, '0, 1'b1, seq_q, drop_q);
              end else if (full) begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                state_d = StEvict;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = app_slot;
                fill_d   = fill_q + 1'b1;
                seq_d    = seq_inc;
                load_out = 1'b1;
                out_d    = make_result(1'b0, seq_inc, cur_due, 1'b1, seq_inc, drop_q);
              end
            end
            ActAck: begin
              if (in_data_i.seq_arg > ack_q) begin
                ack_d = in_data_i.seq_arg;
              end
              load_out = 1'b1;
              out_d    = make_result(1'b0, '0, '0, 1'b1, seq_q, drop_q);
            end
            ActRead: begin
              state_d    = StScan;
              scan_idx_d = head_q;
              scan_cnt_d = fill_q;
              rvalid_d   = 1'b0;
            end
            default: begin
              load_out = 1'b1;
              out_d    = make_result(1'b1, '0, '0, 1'b1, seq_q, drop_q);
            end
          endcase
        end
      end
      StEvict: begin
        drop_d   = drop_q + SeqW'(drop_hit);
        wr_en    = 1'b1;
        wr_addr  = head_q;
        head_d   = head_inc;
        seq_d    = seq_inc;
        load_out = 1'b1;
        out_d    = make_result(1'b0, seq_inc, cur_due, 1'b1, seq_inc,
                               drop_q + SeqW'(drop_hit));
        state_d  = StIdle;
      end
      StScan: begin
        if (!rvalid_q && (scan_cnt_q == '0)) begin
          if (out_free) begin
            load_out = 1'b1;
            out_d    = make_result(1'b0, '0, '0, 1'b1, seq_q, drop_q);
            state_d  = StIdle;
          end
        end else if (!rvalid_q || !match || out_free) begin
          if (rvalid_q && match) begin
            load_out          = 1'b1;
            out_d             = make_result(1'b0, r_seq, rd_data[DueLo +: TimeW], 1'b0,
                                            seq_q, drop_q);
            out_d.has_event   = 1'b1;
            out_d.out_type    = TagW'(rd_data[0 +: TB]);
            out_d.out_channel = TagW'(rd_data[ChanLo +: TB]);
            out_d.out_root    = TagW'(rd_data[RootLo +: TB]);
            out_d.out_actor   = TagW'(rd_data[ActorLo +: TB]);
            out_d.out_note    = TagW'(rd_data[NoteLo +: TB]);
          end
          if (scan_cnt_q != '0) begin
            rd_en      = 1'b1;
            rd_addr    = scan_idx_q;
            scan_idx_d = scan_inc;
            scan_cnt_d = scan_cnt_q - 1'b1;
            rvalid_d   = 1'b1;
          end else begin
            rvalid_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      fill_q      <= '0;
      seq_q       <= '0;
      drop_q      <= '0;
      ack_q       <= '0;
      scan_cnt_q  <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      seq_q       <= seq_d;
      drop_q      <= drop_d;
      ack_q       <= ack_d;
      scan_cnt_q  <= scan_cnt_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    scan_idx_q <= scan_idx_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CW'(DEPTH))
    else $error("Fill count exceeds the ring depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) ack_q >= $past(ack_q))
    else $error("Ack watermark decreased.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   wr_en |=> seq_q == $past(seq_q) + 1'b1)
    else $error("Entry written without a new sequence number.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_en && rd_en))
    else $error("RAM read and write issued in the same cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   load_out |-> (!out_valid_q || out_ready_i))
    else $error("Output register overwritten before its transaction completed.");

endmodule

[sim/tb.sv]
// ============================================================================
// tb
// Self-checking testbench of the acknowledged event ring log. A queue of
// commands (directed corner cases, then constrained-random traffic, then a
// short closing sequence) feeds a valid/ready driver. Both the sender and the
// receiver pause at random, and once the receiver stalls for a long stretch.
// A behavioral copy of the ring computes the results each accepted
// transaction should cause, and a monitor compares them field by field.
// ============================================================================
module tb;
  import aerl_pkg::*;

  localparam int unsigned RingDepth      = DefDepth;
  localparam logic [1:0]  ActUnused      = 2'd3;
  localparam int unsigned RandomItems    = 106;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned DrainCycles    = 40;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned HoldAfterItems = 45;
  localparam int unsigned MaxReports     = 100;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  pending_cmds[$];
  out_t awaited_results[$];

  logic in_accepted  = 1'b0;
  logic out_accepted = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned recv_gap  = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  int unsigned cycles       = 0;
  int unsigned cmds_taken   = 0;
  int unsigned results_seen = 0;
  int unsigned listed_seen  = 0;
  int unsigned mismatches   = 0;
  int unsigned rejects      = 0;
  int unsigned overwrites   = 0;

  // Behavioral copy of the ring.
  logic [SeqW-1:0]  ring_seq     [RingDepth];
  logic [TimeW-1:0] ring_due     [RingDepth];
  logic [TagW-1:0]  ring_type    [RingDepth];
  logic [TagW-1:0]  ring_channel [RingDepth];
  logic [TagW-1:0]  ring_root    [RingDepth];
  logic [TagW-1:0]  ring_actor   [RingDepth];
  logic [TagW-1:0]  ring_note    [RingDepth];
  int unsigned      ring_head  = 0;
  int unsigned      ring_fill  = 0;
  logic [SeqW-1:0]  seq_count  = '0;
  logic [SeqW-1:0]  drop_count = '0;
  logic [SeqW-1:0]  ack_level  = '0;

  acked_event_ring_log i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #6 clk = ~clk;

  function automatic out_t result_base(logic status, logic [SeqW-1:0] seq,
                                       logic [TimeW-1:0] due, logic last);
    out_t r;
    r            = '0;
    r.status     = status;
    r.event_seq  = seq;
    r.event_due  = due;
    r.latest_seq = seq_count;
    r.drop_total = drop_count;
    r.last       = last;
    return r;
  endfunction

  function automatic void ring_log_step(in_t cmd);
    int unsigned      slot;
    int unsigned      idx;
    logic [TimeW-1:0] due;
    out_t             r;
    case (cmd.action)
      ActEmit: begin
        if (cmd.type_tag == '0) begin
          rejects++;
          awaited_results.push_back(result_base(1'b1, '0, '0, 1'b1));
        end else begin
          if (ring_fill < RingDepth) begin
            slot = (ring_head + ring_fill) % RingDepth;
            ring_fill++;
          end else begin
            slot = ring_head;
            overwrites++;
            if (ring_seq[slot] > ack_level) drop_count++;
            ring_head = (slot + 1) % RingDepth;
          end
          seq_count++;
          due = (cmd.due_in != '0) ? cmd.due_in : cmd.now_time;
          ring_seq[slot]     = seq_count;
          ring_due[slot]     = due;
          ring_type[slot]    = cmd.type_tag;
          ring_channel[slot] = cmd.channel_tag;
          ring_root[slot]    = cmd.root_tag;
          ring_actor[slot]   = cmd.actor_tag;
          ring_note[slot]    = cmd.note_tag;
          awaited_results.push_back(result_base(1'b0, seq_count, due, 1'b1));
        end
      end
      ActAck: begin
        if (cmd.seq_arg > ack_level) ack_level = cmd.seq_arg;
        awaited_results.push_back(result_base(1'b0, '0, '0, 1'b1));
      end
      ActRead: begin
        for (int unsigned i = 0; i < ring_fill; i++) begin
          idx = (ring_head + i) % RingDepth;
          if (ring_seq[idx] > cmd.seq_arg) begin
            r             = result_base(1'b0, ring_seq[idx], ring_due[idx], 1'b0);
            r.has_event   = 1'b1;
            r.out_type    = ring_type[idx];
            r.out_channel = ring_channel[idx];
            r.out_root    = ring_root[idx];
            r.out_actor   = ring_actor[idx];
            r.out_note    = ring_note[idx];
            awaited_results.push_back(r);
          end
        end
        awaited_results.push_back(result_base(1'b0, '0, '0, 1'b1));
      end
      default: begin
        rejects++;
        awaited_results.push_back(result_base(1'b1, '0, '0, 1'b1));
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("cycle %0d: mismatch: %s", cycles, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s got 0x%0h expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((cycles / 300) % 5 == 4) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [TimeW-1:0] random_time();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TagW-1:0] random_tag();
    return TagW'($urandom);
  endfunction

  function automatic in_t random_cmd();
    in_t c;
    c.action      = 2'($urandom_range(0, 3));
    c.type_tag    = random_tag();
    c.channel_tag = random_tag();
    c.root_tag    = random_tag();
    c.actor_tag   = random_tag();
    c.note_tag    = random_tag();
    c.due_in      = random_time();
    c.now_time    = random_time();
    c.seq_arg     = $urandom;
    return c;
  endfunction

  function automatic in_t emit_cmd(logic [TagW-1:0] tag, logic [TimeW-1:0] due,
                                   logic [TimeW-1:0] now);
    in_t c;
    c          = random_cmd();
    c.action   = ActEmit;
    c.type_tag = tag;
    c.due_in   = due;
    c.now_time = now;
    return c;
  endfunction

  function automatic in_t seq_cmd(logic [1:0] act, logic [SeqW-1:0] arg);
    in_t c;
    c         = random_cmd();
    c.action  = act;
    c.seq_arg = arg;
    return c;
  endfunction

  function automatic logic [SeqW-1:0] lagged(int unsigned head, int unsigned lag);
    return (head > lag) ? head - lag : 0;
  endfunction

  task automatic build_stimulus();
    in_t         c;
    int unsigned pick;
    int unsigned gen_seq;
    gen_seq = 0;

    pending_cmds.push_back(seq_cmd(ActRead, '0));
    pending_cmds.push_back(emit_cmd('0, random_time(), random_time()));
    c        = random_cmd();
    c        = '1;
    c.action = ActUnused;
    pending_cmds.push_back(c);
    c = emit_cmd('1, 64'sh7FFF_FFFF_FFFF_FFFF, '0);
    c.channel_tag = '1;
    c.root_tag    = '1;
    c.actor_tag   = '1;
    c.note_tag    = '1;
    pending_cmds.push_back(c);
    pending_cmds.push_back(emit_cmd(16'h0001, 64'sh8000_0000_0000_0000, random_time()));
    pending_cmds.push_back(emit_cmd(random_tag(), '0, 64'sh7FFF_FFFF_FFFF_FFFF));
    pending_cmds.push_back(emit_cmd(random_tag(), '0, 64'sh8000_0000_0000_0000));
    pending_cmds.push_back(emit_cmd(random_tag(), '0, '0));
    pending_cmds.push_back(emit_cmd(random_tag(), '1, random_time()));
    pending_cmds.push_back(seq_cmd(ActAck, 32'd2));
    pending_cmds.push_back(seq_cmd(ActAck, 32'd1));
    pending_cmds.push_back(seq_cmd(ActRead, '0));
    pending_cmds.push_back(seq_cmd(ActRead, 32'd3));
    pending_cmds.push_back(seq_cmd(ActRead, '1));
    c = emit_cmd(16'h0001, random_time(), random_time());
    c.channel_tag = '0;
    c.root_tag    = '0;
    c.actor_tag   = '0;
    c.note_tag    = '0;
    pending_cmds.push_back(c);
    pending_cmds.push_back(seq_cmd(ActAck, '0));
    pending_cmds.push_back(seq_cmd(ActUnused, $urandom));
    gen_seq = 8;

    for (int unsigned k = 0; k < RandomItems; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        c = emit_cmd(random_tag(), ($urandom_range(0, 3) == 0) ? '0 : random_time(),
                     random_time());
        if ($urandom_range(0, 19) == 0) c.type_tag = '0;
      end else if (pick < 70) begin
        c = seq_cmd(ActAck, lagged(gen_seq, ($urandom_range(0, 3) == 0) ?
                                            $urandom_range(0, 8) :
                                            $urandom_range(20, 60)));
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0:       c = seq_cmd(ActRead, '0);
          1:       c = seq_cmd(ActRead, $urandom);
          default: c = seq_cmd(ActRead, lagged(gen_seq, $urandom_range(0, 40)));
        endcase
      end else if (pick < 95) begin
        c = seq_cmd(ActUnused, $urandom);
      end else begin
        c = random_cmd();
        if (c.action == ActAck) c.seq_arg = $urandom_range(0, gen_seq);
      end
      if (c.action == ActEmit && c.type_tag != '0) gen_seq++;
      pending_cmds.push_back(c);
    end

    // With every sequence acknowledged, further overwrites are not drops.
    pending_cmds.push_back(seq_cmd(ActAck, '1));
    for (int unsigned k = 0; k < 4; k++) begin
      pending_cmds.push_back(emit_cmd(random_tag(), random_time(), random_time()));
      gen_seq++;
    end
    pending_cmds.push_back(seq_cmd(ActRead, '0));
    pending_cmds.push_back(seq_cmd(ActRead, lagged(gen_seq, 2)));
  endtask

  // Sender.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_accepted)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_cmds.size() > 0) begin
        in_data  <= pending_cmds.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_accepted) recv_gap <= pick_gap();
      end
    end
  end

  // Long receiver stall so that the block fills and back-pressures its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && cmds_taken >= HoldAfterItems) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // Monitor and checker.
  always @(posedge clk) begin
    out_t want;
    in_accepted  <= rst_n && in_valid && in_ready;
    out_accepted <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        ring_log_step(in_data);
        cmds_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          want = awaited_results.pop_front();
          if (want.has_event) listed_seen++;
          check_field("status",      64'(out_data.status),      64'(want.status));
          check_field("has_event",   64'(out_data.has_event),   64'(want.has_event));
          check_field("event_seq",   64'(out_data.event_seq),   64'(want.event_seq));
          check_field("event_due",   64'(out_data.event_due),   64'(want.event_due));
          check_field("out_type",    64'(out_data.out_type),    64'(want.out_type));
          check_field("out_channel", 64'(out_data.out_channel), 64'(want.out_channel));
          check_field("out_root",    64'(out_data.out_root),    64'(want.out_root));
          check_field("out_actor",   64'(out_data.out_actor),   64'(want.out_actor));
          check_field("out_note",    64'(out_data.out_note),    64'(want.out_note));
          check_field("latest_seq",  64'(out_data.latest_seq),  64'(want.latest_seq));
          check_field("drop_total",  64'(out_data.drop_total),  64'(want.drop_total));
          check_field("last",        64'(out_data.last),        64'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, awaited_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int unsigned i = 0; i < RingDepth; i++) begin
      ring_seq[i]     = '0;
      ring_due[i]     = '0;
      ring_type[i]    = '0;
      ring_channel[i] = '0;
      ring_root[i]    = '0;
      ring_actor[i]   = '0;
      ring_note[i]    = '0;
    end
    build_stimulus();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    end
    $display("Checked %0d results from %0d transactions: %0d listed entries, %0d rejects.",
             results_seen, cmds_taken, listed_seen, rejects);
    $display("The ring was overwritten %0d times with %0d drops; %0d mismatches.",
             overwrites, drop_count, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
sv/aerl_pkg.sv
sv/aerl_ram.sv
sv/acked_event_ring_log.sv
sim/tb.sv
